### src/cfd_pkg.sv
// Package for the COBS frame decoder: shared types, constants and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam int MAX_FRAME_DEF  = 512;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int LEN_W          = 10;
  localparam int BYTE_W         = 8;

  // code byte that opens a group with no trailing zero
  localparam logic [BYTE_W-1:0] NO_ZERO_CODE = 8'hFF;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] data;
    logic              frame_end;
    logic              frame_error;
  } result_t;

endpackage

`default_nettype wire

### src/cfd_front.sv
// Front end: frame/group tracking and classification of each accepted byte.
// Uses cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_front #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [cfd_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_frame_start,
  input  wire logic [cfd_pkg::LEN_W-1:0]   in_frame_length,
  output cfd_pkg::result_t                 res,
  output logic                             res_push
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int CMP_W = (CNT_W > cfd_pkg::LEN_W) ? CNT_W : cfd_pkg::LEN_W;

  logic [CNT_W-1:0]          bytes_left_r, bytes_left_nxt;
  logic [cfd_pkg::BYTE_W-1:0] group_left_r, group_left_nxt;
  logic                      zero_pending_r, zero_pending_nxt;
  logic                      discarding_r, discarding_nxt;

  logic [CMP_W-1:0]          len_ext;
  logic [CMP_W-1:0]          len_clamp;
  logic [CMP_W-1:0]          byte_ext;
  logic [CNT_W-1:0]          bl;
  logic [cfd_pkg::BYTE_W-1:0] gl;
  logic                      zp;
  logic                      disc;
  logic                      emit;
  cfd_pkg::result_t          res_w;

  assign len_ext   = CMP_W'(in_frame_length);
  assign len_clamp = (len_ext > CMP_W'(MAX_FRAME)) ? CMP_W'(MAX_FRAME) : len_ext;
  assign byte_ext  = CMP_W'(in_byte);

  // a frame start resets the tracking before the byte itself is looked at
  assign bl   = in_frame_start ? CNT_W'(len_clamp) : bytes_left_r;
  assign gl   = in_frame_start ? '0 : group_left_r;
  assign zp   = in_frame_start ? 1'b0 : zero_pending_r;
  assign disc = in_frame_start ? 1'b0 : discarding_r;

  always_comb begin
    bytes_left_nxt   = bl;
    group_left_nxt   = gl;
    zero_pending_nxt = zp;
    discarding_nxt   = disc;
    res_w            = '0;
    emit             = 1'b0;
    if (disc || bl == '0) begin
      emit = 1'b0;
    end else if (gl != '0) begin
      res_w.byte_valid = 1'b1;
      res_w.data       = in_byte;
      group_left_nxt   = gl - 1'b1;
      bytes_left_nxt   = bl - 1'b1;
    end else if (byte_ext > CMP_W'(bl)) begin
      // group overruns the frame: pay the owed zero and stop
      res_w.byte_valid  = zp;
      res_w.frame_end   = 1'b1;
      res_w.frame_error = 1'b1;
      discarding_nxt    = 1'b1;
      bytes_left_nxt    = '0;
      group_left_nxt    = '0;
      zero_pending_nxt  = 1'b0;
    end else begin
      res_w.byte_valid = zp;
      group_left_nxt   = (in_byte == '0) ? '0 : in_byte - 1'b1;
      zero_pending_nxt = (in_byte != cfd_pkg::NO_ZERO_CODE);
      bytes_left_nxt   = bl - 1'b1;
    end
    if (!disc && bl == CNT_W'(1) && !res_w.frame_error) begin
      res_w.frame_end  = 1'b1;
      group_left_nxt   = '0;
      zero_pending_nxt = 1'b0;
    end
    emit = res_w.byte_valid || res_w.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r   <= '0;
      group_left_r   <= '0;
      zero_pending_r <= 1'b0;
      discarding_r   <= 1'b0;
    end else if (accept) begin
      bytes_left_r   <= bytes_left_nxt;
      group_left_r   <= group_left_nxt;
      zero_pending_r <= zero_pending_nxt;
      discarding_r   <= discarding_nxt;
    end
  end

  assign res      = res_w;
  assign res_push = accept && emit;

endmodule

`default_nettype wire

### src/cfd_fifo.sv
// Short result queue between front end and output stage.
// Uses cfd_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module cfd_fifo #(
  parameter int DEPTH = cfd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire cfd_pkg::result_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output cfd_pkg::result_t      rd_data,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfd_pkg::result_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  assign rd_data = mem[rd_ptr_r];

endmodule

`default_nettype wire

### src/cfd_back.sv
// Output stage: holds the oldest decoded word on the result ports.
// Uses cfd_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module cfd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire cfd_pkg::result_t q_data,
  output logic                  q_rd,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output cfd_pkg::result_t      out_res
);

  logic             out_vld_r;
  cfd_pkg::result_t out_res_r;
  logic             load;

  // refill when the register is free or being taken this cycle
  assign load = !q_empty && (!out_vld_r || out_pop);
  assign q_rd = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= q_data;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

### src/cobs_frame_decoder.sv
// COBS frame decoder, top level. Instantiates cfd_front, cfd_fifo, cfd_back.
// Throughput: one encoded byte per cycle while in_full is low; the front end
// updates the frame counters in the accept cycle. A result enters the queue at
// the edge that accepts its byte, then the output register once that is free.
// in_full rises only when the FIFO_DEPTH-entry result queue is full.
// Reset (synchronous, rst_n low): no frame active, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module cobs_frame_decoder #(
  parameter int MAX_FRAME  = cfd_pkg::MAX_FRAME_DEF,
  parameter int FIFO_DEPTH = cfd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [cfd_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_frame_start,
  input  wire logic [cfd_pkg::LEN_W-1:0]   in_frame_length,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic                             out_byte_valid,
  output logic [cfd_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_frame_end,
  output logic                             out_frame_error
);

  logic             accept;
  cfd_pkg::result_t f_res;
  logic             f_push;
  cfd_pkg::result_t q_data;
  logic             q_empty;
  logic             q_rd;
  cfd_pkg::result_t o_res;

  assign accept = in_push && !in_full;

  cfd_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_byte         (in_byte),
    .in_frame_start  (in_frame_start),
    .in_frame_length (in_frame_length),
    .res             (f_res),
    .res_push        (f_push)
  );

  cfd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_res),
    .full    (in_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (o_res)
  );

  assign out_byte_valid  = o_res.byte_valid;
  assign out_byte        = o_res.data;
  assign out_frame_end   = o_res.frame_end;
  assign out_frame_error = o_res.frame_error;

endmodule

`default_nettype wire
